>>> rtl/wrs_pkg.sv
package wrs_pkg;

  localparam int MAX_ENTRIES_DEF      = 1024;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int LABEL_W  = 16;
  localparam int WEIGHT_W = 17;
  localparam int RAND_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW_W   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DRAW_UNC = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CHOSEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic wr;
    logic rd;
  } tbl_ctl_t;

endpackage

>>> rtl/wrs_table.sv
module wrs_table
  import wrs_pkg::*;
#(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(MAX_ENTRIES_DEF)
) (
  input  logic                clk,
  input  tbl_ctl_t            ctl,
  input  logic [AW-1:0]       waddr,
  input  logic [LABEL_W-1:0]  wlabel,
  input  logic [WEIGHT_W-1:0] wweight,
  input  logic [AW-1:0]       raddr,
  output logic [LABEL_W-1:0]  rlabel,
  output logic [WEIGHT_W-1:0] rweight
);

  logic [LABEL_W-1:0]  label_mem  [DEPTH];
  logic [WEIGHT_W-1:0] weight_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      label_mem[waddr]  <= wlabel;
      weight_mem[waddr] <= wweight;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rlabel  <= label_mem[raddr];
      rweight <= weight_mem[raddr];
    end
  end

endmodule

>>> rtl/wrs_engine.sv
module wrs_engine
  import wrs_pkg::*;
#(
  parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int AW               = $clog2(MAX_ENTRIES_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [MODE_W-1:0]   mode,
  input  logic [LABEL_W-1:0]  entry_label,
  input  logic [WEIGHT_W-1:0] entry_weight,
  input  logic [RAND_W-1:0]   random_fraction,
  output logic                busy,
  output tbl_ctl_t            tbl_ctl,
  output logic [AW-1:0]       tbl_waddr,
  output logic [LABEL_W-1:0]  tbl_wlabel,
  output logic [WEIGHT_W-1:0] tbl_wweight,
  output logic [AW-1:0]       tbl_raddr,
  input  logic [LABEL_W-1:0]  tbl_rlabel,
  input  logic [WEIGHT_W-1:0] tbl_rweight,
  output logic                fin_valid,
  input  logic                fin_take,
  output logic [LABEL_W-1:0]  fin_label,
  output logic [STATUS_W-1:0] fin_status
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int SW   = WEIGHT_W + 1;
  localparam int EW   = (WEIGHT_FRAC_BITS + 2 > SW) ? WEIGHT_FRAC_BITS + 2 : SW;
  localparam int TW   = SW + CW;
  localparam int PW   = TW + RAND_W;
  localparam int MB_W = $clog2(RAND_W);

  localparam logic [EW-1:0] ONE_E  = {{(EW-1){1'b0}}, 1'b1} << WEIGHT_FRAC_BITS;
  localparam logic [EW-1:0] HALF_E = ONE_E >> 1;
  localparam logic [CW-1:0] CAP    = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic                rd_pend;
  logic                unc;
  logic [RAND_W-1:0]   rnd;
  logic [MB_W-1:0]     mbit;
  logic [TW-1:0]       acc;
  logic [TW-1:0]       cum;
  logic [PW-1:0]       target;
  logic [LABEL_W-1:0]  pick;
  logic [LABEL_W-1:0]  res_label;
  logic [STATUS_W-1:0] res_status;

  logic [PW-1:0]       add_a;
  logic [PW-1:0]       add_b;
  logic [PW-1:0]       add_sum;
  logic [SW-1:0]       sel_r;
  logic                issue;
  logic                append_ok;
  logic                cum_hit;
  logic                sat;
  logic [EW-1:0]       wt_e;

  // selection weight: plain, or 2*min(w, 1-w)
  function automatic logic [SW-1:0] sel_of(input logic [WEIGHT_W-1:0] w, input logic by_unc);
    logic [EW-1:0] we;
    logic [EW-1:0] r;
    we = EW'(w);
    if (!by_unc) begin
      r = we;
    end else if (we > HALF_E) begin
      r = (we >= ONE_E) ? '0 : ((ONE_E - we) << 1);
    end else begin
      r = we << 1;
    end
    return r[SW-1:0];
  endfunction

  assign sel_r     = sel_of(tbl_rweight, unc);
  assign issue     = ((state == S_SUM) || (state == S_SCAN)) && (idx < count);
  assign append_ok = go && (mode == MODE_APPEND) && (count < CAP);
  assign wt_e      = EW'(entry_weight);
  assign sat       = wt_e > ONE_E;

  assign tbl_ctl.wr  = append_ok;
  assign tbl_ctl.rd  = issue;
  assign tbl_waddr   = count[AW-1:0];
  assign tbl_wlabel  = entry_label;
  assign tbl_wweight = sat ? ONE_E[WEIGHT_W-1:0] : entry_weight;
  assign tbl_raddr   = idx[AW-1:0];

  // shared adder: total pass, shift-add product, cumulative pass
  always_comb begin
    case (state)
      S_SUM: begin
        add_a = PW'(acc);
        add_b = PW'(sel_r);
      end
      S_MUL: begin
        add_a = {target[PW-2:0], 1'b0};
        add_b = rnd[mbit] ? PW'(acc) : '0;
      end
      S_SCAN: begin
        add_a = PW'(cum);
        add_b = PW'(sel_r);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;
  assign cum_hit = {add_sum[TW-1:0], {RAND_W{1'b0}}} >= target;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            case (mode)
              MODE_CLEAR: begin
                count      <= '0;
                res_label  <= '0;
                res_status <= ST_OK;
                state      <= S_FIN;
              end
              MODE_APPEND: begin
                res_label <= '0;
                if (append_ok) begin
                  count      <= count + 1'b1;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_FULL;
                end
                state <= S_FIN;
              end
              default: begin
                unc     <= (mode == MODE_DRAW_UNC);
                rnd     <= random_fraction;
                acc     <= '0;
                idx     <= '0;
                rd_pend <= 1'b0;
                state   <= S_SUM;
              end
            endcase
          end
        end
        S_SUM: begin
          rd_pend <= issue;
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend) begin
            acc <= add_sum[TW-1:0];
          end
          if (!issue && !rd_pend) begin
            if (acc == '0) begin
              res_label  <= '0;
              res_status <= ST_ZERO;
              state      <= S_FIN;
            end else begin
              target <= '0;
              mbit   <= '1;
              state  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          target <= add_sum;
          if (mbit == '0) begin
            idx     <= '0;
            rd_pend <= 1'b0;
            cum     <= '0;
            pick    <= '0;
            state   <= S_SCAN;
          end else begin
            mbit <= mbit - 1'b1;
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend && (sel_r != '0)) begin
            cum  <= add_sum[TW-1:0];
            pick <= tbl_rlabel;
            if (cum_hit) begin
              res_label  <= tbl_rlabel;
              res_status <= ST_CHOSEN;
              state      <= S_FIN;
            end
          end else if (!issue && !rd_pend) begin
            res_label  <= pick;
            res_status <= ST_CHOSEN;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign fin_valid  = (state == S_FIN);
  assign fin_label  = res_label;
  assign fin_status = res_status;

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("entry count beyond capacity");

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && go && (mode == MODE_DRAW_W || mode == MODE_DRAW_UNC))
      |=> state == S_SUM)
    else $error("draw did not start the total pass");

  a_mul_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> acc != '0)
    else $error("product pass with zero total");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (issue || rd_pend))
    else $error("scan ran past the last entry");

endmodule

>>> rtl/weighted_roulette_selector.sv
// Roulette-wheel selector over a table of labelled weights (1.0 = 2^WEIGHT_FRAC_BITS).
// A clear or append word moves its result through the engine's finish state into the
// output register, and the next word can be taken once the engine is back in idle. A
// draw forms its result in steps: one pass over the table to form the total, sixteen
// shift-add steps to scale it by the random fraction, then a second pass that stops at
// the first entry whose cumulative weight reaches the target (or else ends on the last
// entry of nonzero weight), and then the finish state hands the result over. A zero
// total ends after the first pass. Each pass reads the table one entry a cycle, and one
// adder is shared by every pass. A new word is taken only once the previous one has
// moved its result into the output register, so a stalled result holds off input.
module weighted_roulette_selector
  import wrs_pkg::*;
#(
  parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [LABEL_W-1:0]  entry_label,
  input  logic [WEIGHT_W-1:0] entry_weight,
  input  logic [RAND_W-1:0]   random_fraction,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [LABEL_W-1:0]  chosen_label,
  output logic [STATUS_W-1:0] status
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic                busy;
  logic                go;
  tbl_ctl_t            tbl_ctl;
  logic [AW-1:0]       tbl_waddr;
  logic [LABEL_W-1:0]  tbl_wlabel;
  logic [WEIGHT_W-1:0] tbl_wweight;
  logic [AW-1:0]       tbl_raddr;
  logic [LABEL_W-1:0]  tbl_rlabel;
  logic [WEIGHT_W-1:0] tbl_rweight;
  logic                fin_valid;
  logic                fin_take;
  logic [LABEL_W-1:0]  fin_label;
  logic [STATUS_W-1:0] fin_status;

  assign item_stall = busy;
  assign go         = item_valid && !busy;
  assign fin_take   = fin_valid && (!result_valid || !result_stall);

  wrs_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .waddr   (tbl_waddr),
    .wlabel  (tbl_wlabel),
    .wweight (tbl_wweight),
    .raddr   (tbl_raddr),
    .rlabel  (tbl_rlabel),
    .rweight (tbl_rweight)
  );

  wrs_engine #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .AW               (AW)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .mode            (mode),
    .entry_label     (entry_label),
    .entry_weight    (entry_weight),
    .random_fraction (random_fraction),
    .busy            (busy),
    .tbl_ctl         (tbl_ctl),
    .tbl_waddr       (tbl_waddr),
    .tbl_wlabel      (tbl_wlabel),
    .tbl_wweight     (tbl_wweight),
    .tbl_raddr       (tbl_raddr),
    .tbl_rlabel      (tbl_rlabel),
    .tbl_rweight     (tbl_rweight),
    .fin_valid       (fin_valid),
    .fin_take        (fin_take),
    .fin_label       (fin_label),
    .fin_status      (fin_status)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      chosen_label <= fin_label;
      status       <= fin_status;
    end
  end

endmodule

>>> tb/weighted_roulette_selector_tb.sv
`timescale 1ns / 1ps

module weighted_roulette_selector_tb;
  import wrs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int LONG_FILL = 60;
  localparam longint unsigned W_ONE = 64'd1 << WEIGHT_FRAC_BITS_DEF;
  localparam longint unsigned W_HALF = 64'd1 << (WEIGHT_FRAC_BITS_DEF - 1);
  localparam longint unsigned FRAC_SCALE = 64'd1 << RAND_W;
  localparam logic [WEIGHT_W-1:0] WT_ONE = WEIGHT_W'(W_ONE);
  localparam logic [WEIGHT_W-1:0] WT_HALF = WEIGHT_W'(W_HALF);
  localparam logic [WEIGHT_W-1:0] WT_MAX = '1;

  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    logic [STATUS_W-1:0] st;
  } outcome_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [MODE_W-1:0]   mode = MODE_CLEAR;
  logic [LABEL_W-1:0]  entry_label = '0;
  logic [WEIGHT_W-1:0] entry_weight = '0;
  logic [RAND_W-1:0]   random_fraction = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [LABEL_W-1:0]  chosen_label;
  logic [STATUS_W-1:0] status;

  // model of the table
  logic [LABEL_W-1:0]  tbl_label[TABLE_DEPTH];
  logic [WEIGHT_W-1:0] tbl_weight[TABLE_DEPTH];
  int unsigned         tbl_count = 0;

  outcome_t pending_outcomes[$];
  outcome_t head;
  int       errors = 0;
  int       cycles = 0;
  bit       word_gaps = 1'b1;
  bit       pick_gaps = 1'b1;

  // handshake state latched mid-cycle, used at the next rising edge
  bit                  word_took = 1'b0;
  bit                  pick_took = 1'b0;
  logic [LABEL_W-1:0]  got_label;
  logic [STATUS_W-1:0] got_status;

  weighted_roulette_selector DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .entry_label     (entry_label),
    .entry_weight    (entry_weight),
    .random_fraction (random_fraction),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .chosen_label    (chosen_label),
    .status          (status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    word_took = (item_valid === 1'b1) && (item_stall === 1'b0);
    pick_took = (result_valid === 1'b1) && (result_stall === 1'b0);
    got_label = chosen_label;
    got_status = status;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_roulette_selector_tb: FAIL");
      $finish;
    end
  end

  function automatic longint unsigned draw_share(logic [WEIGHT_W-1:0] w, bit by_unc);
    longint unsigned v;
    v = w;
    if (!by_unc)
      return v;
    if (v > W_HALF)
      return (v >= W_ONE) ? 64'd0 : (W_ONE - v) * 2;
    return v * 2;
  endfunction

  function automatic outcome_t roulette_predict(logic [MODE_W-1:0] m, logic [LABEL_W-1:0] lbl,
                                                logic [WEIGHT_W-1:0] wt,
                                                logic [RAND_W-1:0] frac);
    outcome_t        o;
    longint unsigned total;
    longint unsigned cum;
    longint unsigned target;
    longint unsigned s;
    bit              by_unc;
    bit              found;
    o.label = '0;
    o.st = ST_OK;
    by_unc = (m == MODE_DRAW_UNC);
    case (m)
      MODE_CLEAR: begin
        tbl_count = 0;
      end
      MODE_APPEND: begin
        if (tbl_count >= TABLE_DEPTH) begin
          o.st = ST_FULL;
        end else begin
          tbl_label[tbl_count] = lbl;
          tbl_weight[tbl_count] = (wt > WT_ONE) ? WT_ONE : wt;
          tbl_count++;
        end
      end
      default: begin
        total = 0;
        for (int i = 0; i < tbl_count; i++)
          total += draw_share(tbl_weight[i], by_unc);
        if (total == 0) begin
          o.st = ST_ZERO;
        end else begin
          target = total * frac;
          cum = 0;
          found = 1'b0;
          for (int i = 0; i < tbl_count; i++) begin
            s = draw_share(tbl_weight[i], by_unc);
            if (!found && s != 0) begin
              cum += s;
              o.label = tbl_label[i];
              found = (cum * FRAC_SCALE >= target);
            end
          end
          o.st = ST_CHOSEN;
        end
      end
    endcase
    return o;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10)
      $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    result_stall <= pick_gaps && ($urandom_range(0, 99) < 12);
    if (!rst && pick_took) begin
      if (pending_outcomes.size() == 0) begin
        flag_error($sformatf("unexpected result label %h status %0d", got_label, got_status));
      end else begin
        head = pending_outcomes.pop_front();
        if (head.label !== got_label)
          flag_error($sformatf("chosen_label exp %h got %h", head.label, got_label));
        if (head.st !== got_status)
          flag_error($sformatf("status exp %0d got %0d", head.st, got_status));
      end
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [LABEL_W-1:0] lbl,
                           input logic [WEIGHT_W-1:0] wt, input logic [RAND_W-1:0] frac);
    while (word_gaps && $urandom_range(0, 99) < 12) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    entry_label <= lbl;
    entry_weight <= wt;
    random_fraction <= frac;
    @(posedge clk);
    while (!word_took)
      @(posedge clk);
    pending_outcomes.insert(pending_outcomes.size(), roulette_predict(m, lbl, wt, frac));
  endtask

  task automatic send_append(input logic [LABEL_W-1:0] lbl, input logic [WEIGHT_W-1:0] wt);
    send_word(MODE_APPEND, lbl, wt, RAND_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_draw(input logic [MODE_W-1:0] m, input logic [RAND_W-1:0] frac);
    send_word(m, LABEL_W'($urandom_range(0, 65535)), WEIGHT_W'($urandom_range(0, 131071)), frac);
  endtask

  function automatic logic [LABEL_W-1:0] rand_label();
    return LABEL_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WT_ONE;
      2: return WEIGHT_W'(W_HALF - 1 + $urandom_range(0, 2));
      3: return WEIGHT_W'($urandom_range(65537, 131071));
      default: return WEIGHT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RAND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] rand_draw_mode();
    return $urandom_range(0, 1) ? MODE_DRAW_UNC : MODE_DRAW_W;
  endfunction

  task automatic test_empty_table();
    send_draw(MODE_DRAW_W, '0);
    send_draw(MODE_DRAW_UNC, '1);
    send_append(16'h0000, '0);
    send_draw(MODE_DRAW_W, 16'h8000);
    send_word(MODE_CLEAR, '1, WT_MAX, '1);
  endtask

  task automatic test_special_weights();
    send_word(MODE_CLEAR, '0, '0, '0);
    send_append(16'hFFFF, WT_ONE);
    send_append(16'h0001, '0);
    send_append(16'h1234, WT_MAX);
    send_append(16'h1234, WT_HALF + 1);
    send_append(16'h8000, WT_HALF);
    send_append(16'h00FF, 17'd1);
    send_draw(MODE_DRAW_W, '0);
    send_draw(MODE_DRAW_W, '1);
    send_draw(MODE_DRAW_W, 16'h8000);
    send_draw(MODE_DRAW_UNC, '0);
    send_draw(MODE_DRAW_UNC, '1);
    send_draw(MODE_DRAW_UNC, 16'd20000);
    send_word(MODE_CLEAR, '1, '0, '1);
    send_append(16'h7777, WT_ONE);
    send_append(16'h4444, '0);
    send_draw(MODE_DRAW_UNC, 16'h4000);
    send_draw(MODE_DRAW_W, '1);
  endtask

  task automatic test_long_table();
    send_word(MODE_CLEAR, rand_label(), rand_weight(), rand_frac());
    for (int i = 0; i < LONG_FILL; i++)
      send_append(rand_label(), rand_weight());
    send_draw(MODE_DRAW_W, '1);
    send_draw(MODE_DRAW_UNC, rand_frac());
    send_draw(MODE_DRAW_W, '0);
    send_draw(MODE_DRAW_UNC, '1);
  endtask

  // mostly clear / fill / draw sessions, with some stray words mixed in
  task automatic test_random_sessions(input int n_words);
    int sent;
    int k;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 85) begin
        send_word(MODE_CLEAR, rand_label(), rand_weight(), rand_frac());
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (int i = 0; i < k; i++)
          send_append(rand_label(), rand_weight());
        sent += k + 1;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_draw(rand_draw_mode(), rand_frac());
        sent += k;
      end else begin
        send_word(MODE_W'($urandom_range(0, 3)), rand_label(), rand_weight(), rand_frac());
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back();
    word_gaps = 1'b0;
    pick_gaps = 1'b0;
    test_random_sessions(50);
    word_gaps = 1'b1;
    pick_gaps = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_special_weights();
    test_long_table();
    test_random_sessions(140);
    test_back_to_back();
    item_valid <= 1'b0;
    while (pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("weighted_roulette_selector_tb: PASS");
    else
      $display("weighted_roulette_selector_tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/wrs_pkg.sv
rtl/wrs_table.sv
rtl/wrs_engine.sv
rtl/weighted_roulette_selector.sv
tb/weighted_roulette_selector_tb.sv
